/* hw/rtl/tsf_pkg.sv */
`default_nettype none

package tsf_pkg;

	localparam int unsigned FIELD_BITS  = 16;
	localparam int unsigned TDATA_BITS  = 3 * FIELD_BITS;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// master tuser bit positions
	localparam int unsigned TUSER_CLIPPED = 0;
	localparam int unsigned TUSER_CONT    = 1;
	localparam int unsigned M_TUSER_BITS  = 2;

	typedef struct packed {
		logic push;
	} tsf_queue_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/tsf_front.sv */
`default_nettype none

module tsf_front import tsf_pkg::*; #(
	parameter int unsigned VERTEX_ID_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [TDATA_BITS-1:0]         s_tdata,
	input  wire logic                          s_tuser,
	input  wire logic                          s_tlast,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	output logic [3*VERTEX_ID_BITS+1:0]        push_data,
	input  wire logic                          q_full,
	output tsf_queue_ctl_t                     q_ctl
);

	localparam int unsigned W = VERTEX_ID_BITS;

	logic [W-1:0] t [3];
	logic [W-1:0] held_q [3];
	logic [W-1:0] rp [3];
	logic [W-1:0] rt [3];
	logic [W-1:0] p_out [3];
	logic [W-1:0] t_out [3];
	logic         held_valid_q;
	logic         held_clipped_q;
	logic         strip_open_q;
	logic         flush_q;
	logic         match;
	logic         both;
	logic         accept;
	logic         push;

	for (genvar i = 0; i < 3; i++) begin : g_in
		assign t[i] = W'(s_tdata[FIELD_BITS*i +: FIELD_BITS]);
	end

	// edge search against the held triangle
	always_comb begin
		logic [W-1:0] a, b, c, d, e, f;
		a = held_q[0]; b = held_q[1]; c = held_q[2];
		d = t[0];      e = t[1];      f = t[2];
		rp = held_q;
		rt = t;
		match = 1'b0;
		if (!strip_open_q) begin
			if (a == d) begin
				if (b == f) begin
					rp = '{c, a, b}; rt = '{a, b, e}; match = 1'b1;
				end else if (c == e) begin
					rp = '{b, c, a}; rt = '{c, a, f}; match = 1'b1;
				end
			end else if (a == e) begin
				if (b == d) begin
					rp = '{c, a, b}; rt = '{a, b, f}; match = 1'b1;
				end else if (c == f) begin
					rp = '{b, c, a}; rt = '{c, a, d}; match = 1'b1;
				end
			end else if (a == f) begin
				if (b == e) begin
					rp = '{c, a, b}; rt = '{a, b, d}; match = 1'b1;
				end else if (c == d) begin
					rp = '{b, c, a}; rt = '{c, a, e}; match = 1'b1;
				end
			end else begin
				if (b == d) begin
					if (c == f) begin
						rt = '{b, c, e}; match = 1'b1;
					end
				end else if (b == f) begin
					if (c == e) begin
						rt = '{b, c, d}; match = 1'b1;
					end
				end else if (b == e) begin
					if (c == d) begin
						rt = '{b, c, f}; match = 1'b1;
					end
				end
			end
		end else begin
			// extend: s = b, t = c of held triangle
			if (d == b) begin
				if (e == c) begin
					match = 1'b1;
				end else if (f == c) begin
					rt = '{d, f, e}; match = 1'b1;
				end
			end else if (e == b) begin
				if (f == c) begin
					rt = '{e, f, d}; match = 1'b1;
				end else if (d == c) begin
					rt = '{e, d, f}; match = 1'b1;
				end
			end else if (f == b) begin
				if (d == c) begin
					rt = '{f, d, e}; match = 1'b1;
				end else if (e == c) begin
					rt = '{f, e, d}; match = 1'b1;
				end
			end
		end
	end

	assign both     = held_valid_q && !held_clipped_q && !s_tuser;
	assign p_out    = both ? rp : held_q;
	assign t_out    = both ? rt : t;
	assign s_tready = !q_full && !flush_q;
	assign accept   = s_tvalid && s_tready;
	assign push     = (accept && (held_valid_q || s_tlast)) || (flush_q && !q_full);

	assign q_ctl.push = push;

	// entry: fin, clipped, third, second, first
	always_comb begin
		if (flush_q) begin
			push_data = {1'b1, held_clipped_q, held_q[2], held_q[1], held_q[0]};
		end else if (held_valid_q) begin
			push_data = {1'b0, held_clipped_q, p_out[2], p_out[1], p_out[0]};
		end else begin
			push_data = {1'b1, s_tuser, t[2], t[1], t[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q   <= 1'b0;
			held_clipped_q <= 1'b0;
			strip_open_q   <= 1'b0;
			flush_q        <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				held_valid_q   <= 1'b0;
				strip_open_q   <= 1'b0;
				flush_q        <= held_valid_q;
				held_clipped_q <= s_tuser;
			end else begin
				held_valid_q   <= 1'b1;
				held_clipped_q <= s_tuser;
				strip_open_q   <= both && match;
			end
		end else if (flush_q && !q_full) begin
			flush_q        <= 1'b0;
			held_clipped_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= t_out;
		end
	end

	a_open_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		strip_open_q |-> held_valid_q)
		else $error("strip open without held triangle");

	a_flush_drains: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q && !q_full |=> !flush_q)
		else $error("flush did not complete");

	a_flush_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> !held_valid_q && !strip_open_q)
		else $error("flush with open state");

endmodule

`default_nettype wire

/* hw/rtl/tsf_queue.sv */
`default_nettype none

module tsf_queue import tsf_pkg::*; #(
	parameter int unsigned WIDTH = 50
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tsf_queue_ctl_t   ctl,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	output logic                  rd_valid,
	output logic [WIDTH-1:0]      rd_data,
	input  wire logic             pop
);

	logic [WIDTH-1:0]          mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      do_push;
	logic                      do_pop;

	assign full     = count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_push  = ctl.push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QUEUE_CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QUEUE_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/tsf_back.sv */
`default_nettype none

module tsf_back import tsf_pkg::*; #(
	parameter int unsigned VERTEX_ID_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire logic [3*VERTEX_ID_BITS+1:0] q_data,
	output logic                            pop,
	output logic [TDATA_BITS-1:0]           m_tdata,
	output logic [M_TUSER_BITS-1:0]         m_tuser,
	output logic                            m_tlast,
	output logic                            m_tvalid,
	input  wire logic                       m_tready
);

	localparam int unsigned W = VERTEX_ID_BITS;

	logic [W-1:0] v0, v1, v2;
	logic         clipped;
	logic         fin;
	logic         cont;
	logic [W-1:0] prior0_q, prior1_q;
	logic         prior_valid_q;

	assign v0      = q_data[0 +: W];
	assign v1      = q_data[W +: W];
	assign v2      = q_data[2*W +: W];
	assign clipped = q_data[3*W];
	assign fin     = q_data[3*W+1];

	assign cont = prior_valid_q && !clipped && prior0_q == v0 && prior1_q == v1;
	assign pop  = q_valid && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid      <= 1'b0;
			prior_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				m_tvalid      <= 1'b1;
				prior_valid_q <= !clipped && !fin;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata  <= {FIELD_BITS'(v2), FIELD_BITS'(v1), FIELD_BITS'(v0)};
			m_tuser  <= {cont, clipped};
			m_tlast  <= fin;
			prior0_q <= v1;
			prior1_q <= v2;
		end
	end

	a_cont_not_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[TUSER_CONT] |-> !m_tuser[TUSER_CLIPPED])
		else $error("clipped triangle marked as strip continuation");

	a_cont_links_prior: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cont |=> m_tdata[FIELD_BITS-1:0] == FIELD_BITS'($past(prior0_q)))
		else $error("continuation does not match prior edge");

	a_last_clears_prior: assert property (@(posedge clk) disable iff (!arst_n)
		pop && fin |=> !prior_valid_q)
		else $error("prior edge survives end of list");

endmodule

`default_nettype wire

/* hw/rtl/triangle_strip_former.sv */
// path: a triangle is held until the next transaction arrives (a lone final one is not held);
// it is written to the queue at that edge and moved into the output register when that is free
// throughput: one triangle per cycle while the queue has room; a final triangle that follows
// a held one is flushed on its own, as the single queue write port forces, with s_tready low
// reset: arst_n clears the held triangle, strip state, queue and output valid
`default_nettype none

module triangle_strip_former import tsf_pkg::*; #(
	parameter int unsigned VERTEX_ID_BITS = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [TDATA_BITS-1:0]   s_tdata,  // vertex_first, vertex_second, vertex_third
	input  wire logic                    s_tuser,  // is_clipped
	input  wire logic                    s_tlast,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	output logic [TDATA_BITS-1:0]        m_tdata,  // out_first, out_second, out_third
	output logic [M_TUSER_BITS-1:0]      m_tuser,  // out_clipped, continues_strip
	output logic                         m_tlast,
	output logic                         m_tvalid,
	input  wire logic                    m_tready
);

	localparam int unsigned ENTRY_BITS = 3 * VERTEX_ID_BITS + 2;

	logic [ENTRY_BITS-1:0] push_data;
	logic [ENTRY_BITS-1:0] q_data;
	tsf_queue_ctl_t        q_ctl;
	logic                  q_full;
	logic                  q_valid;
	logic                  pop;

	tsf_front #(.VERTEX_ID_BITS(VERTEX_ID_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.push_data (push_data),
		.q_full    (q_full),
		.q_ctl     (q_ctl)
	);

	tsf_queue #(.WIDTH(ENTRY_BITS)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (q_ctl),
		.wr_data  (push_data),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_data  (q_data),
		.pop      (pop)
	);

	tsf_back #(.VERTEX_ID_BITS(VERTEX_ID_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.pop      (pop),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

endmodule

`default_nettype wire
